/* rtl/binary_beep_tone_keyer_core_macros.svh */
// Assertion macros shared by the keyer RTL.
`ifndef BINARY_BEEP_TONE_KEYER_CORE_MACROS_SVH
`define BINARY_BEEP_TONE_KEYER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BBTK_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bbtk: invariant violated");
`define BBTK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbtk: next-cycle check failed");
`else
`define BBTK_ASSERT_ALWAYS(label, expr)
`define BBTK_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/bbtk_pkg.sv */
// Package: types, constants and the sine table function of the tone keyer.
`default_nettype none
package bbtk_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF      = 20;

    localparam int LEN_W       = 20;
    localparam int INC_W       = 32;
    localparam int AMP_W       = 15;
    localparam int MAG_W       = 15;
    localparam int SAMPLE_W    = 16;
    localparam int CHAR_W      = 8;
    localparam int REQ_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    localparam logic [LEN_W-1:0] SHORT_RST    = 20'd4410;
    localparam logic [LEN_W-1:0] LONG_RST     = 20'd4410;
    localparam logic [LEN_W-1:0] BIT_GAP_RST  = 20'd2205;
    localparam logic [LEN_W-1:0] BYTE_GAP_RST = 20'd8820;
    localparam logic [LEN_W-1:0] END_RST      = 20'd13230;
    localparam logic [INC_W-1:0] TONE_INC_RST = 32'd85704562;
    localparam logic [INC_W-1:0] END_INC_RST  = 32'd42852281;
    localparam logic [AMP_W-1:0] AMP_RST      = 15'd30000;

    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CHAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_GAP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_INC = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_INC  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP      = 3'd7;

    localparam real TWO_PI = 2.0 * 3.14159265358979323846;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_BIT0  = 3'd1,
        CMD_BIT1  = 3'd2,
        CMD_SPACE = 3'd3,
        CMD_END   = 3'd4,
        CMD_OTHER = 3'd5,
        CMD_NONE  = 3'd6
    } cmd_t;

    typedef enum logic [5:0] {
        KIND_IDLE     = 6'b000001,
        KIND_SHORT    = 6'b000010,
        KIND_LONG     = 6'b000100,
        KIND_BIT_GAP  = 6'b001000,
        KIND_BYTE_GAP = 6'b010000,
        KIND_END      = 6'b100000
    } kind_t;

    typedef struct packed {
        logic tone;
        logic playing;
        logic accepted;
        logic idle;
    } res_flags_t;

    // 32767*sin(2*pi*k/2^bits), rounded to nearest; first quadrant only
    function automatic logic [MAG_W-1:0] quarter_sine(int k, int bits);
        real ang;
        real v;
        ang = TWO_PI * real'(k) * (0.5 ** bits);
        v   = 32767.0 * $sin(ang) + 0.5;
        return MAG_W'($rtoi(v));
    endfunction

endpackage
`default_nettype wire

/* rtl/bbtk_front.sv */
// Front end: classifies incoming items and queues them for the sequencer.
`default_nettype none
`include "binary_beep_tone_keyer_core_macros.svh"
module bbtk_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bbtk_pkg::CHAR_W-1:0]   s_tdata,
    input  wire logic [bbtk_pkg::REQ_W-1:0]    s_tuser,
    input  wire logic                          advance,
    output logic                               q_valid,
    output bbtk_pkg::cmd_t                     q_cmd
);

    localparam logic [1:0] QueueDepth = 2'd2;

    bbtk_pkg::cmd_t cls;
    bbtk_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    always_comb
    begin
        case (s_tuser)
            bbtk_pkg::REQ_TICK: cls = bbtk_pkg::CMD_TICK;
            bbtk_pkg::REQ_CHAR:
            begin
                if (s_tdata == bbtk_pkg::CH_ZERO)
                    cls = bbtk_pkg::CMD_BIT0;
                else if (s_tdata == bbtk_pkg::CH_ONE)
                    cls = bbtk_pkg::CMD_BIT1;
                else if (s_tdata == bbtk_pkg::CH_SPACE)
                    cls = bbtk_pkg::CMD_SPACE;
                else
                    cls = bbtk_pkg::CMD_OTHER;
            end
            bbtk_pkg::REQ_END:  cls = bbtk_pkg::CMD_END;
            default:            cls = bbtk_pkg::CMD_NONE;
        endcase
    end

    assign s_tready = (count_reg != QueueDepth);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && advance;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls;
    end

    `BBTK_ASSERT_ALWAYS(a_queue_bound, count_reg <= QueueDepth)
    `BBTK_ASSERT_NEXT(a_push_fills, push && !pop, count_reg != 2'd0)

endmodule
`default_nettype wire

/* rtl/bbtk_back.sv */
// Back end: segment sequencer that carries out one queued item per cycle while advance is high.
`default_nettype none
`include "binary_beep_tone_keyer_core_macros.svh"
module bbtk_back
#(
    parameter int SINE_TABLE_BITS = bbtk_pkg::SINE_TABLE_BITS_DEF,
    parameter int COUNT_BITS      = bbtk_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         q_valid,
    input  wire bbtk_pkg::cmd_t               q_cmd,
    input  wire logic [bbtk_pkg::LEN_W-1:0]   short_len,
    input  wire logic [bbtk_pkg::LEN_W-1:0]   long_len,
    input  wire logic [bbtk_pkg::LEN_W-1:0]   bit_gap_len,
    input  wire logic [bbtk_pkg::LEN_W-1:0]   byte_gap_len,
    input  wire logic [bbtk_pkg::LEN_W-1:0]   end_len,
    input  wire logic [bbtk_pkg::INC_W-1:0]   tone_inc,
    input  wire logic [bbtk_pkg::INC_W-1:0]   end_inc,
    output logic                              s1_valid,
    output bbtk_pkg::res_flags_t              s1_flags,
    output logic [SINE_TABLE_BITS-1:0]        s1_index
);

    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    logic [bbtk_pkg::INC_W-1:0] phase_reg,  phase_next;
    logic [COUNT_BITS-1:0]      left_reg,   left_next;
    bbtk_pkg::kind_t            seg_reg,    seg_next;
    bbtk_pkg::kind_t            queued_reg, queued_next;
    logic                       gap_reg,    gap_next;
    logic                       open_reg,   open_next;

    logic                       s1_valid_reg;
    bbtk_pkg::res_flags_t       s1_flags_reg;
    logic [SINE_TABLE_BITS-1:0] s1_index_reg;

    bbtk_pkg::res_flags_t       flags;
    bbtk_pkg::kind_t            first_k;
    bbtk_pkg::kind_t            second_k;
    logic                       do_launch;
    logic                       busy;
    logic                       pop;
    logic [COUNT_BITS-1:0]      left_dec;
    logic [COUNT_BITS-1:0]      len_first;
    logic [COUNT_BITS-1:0]      len_second;
    logic [COUNT_BITS-1:0]      len_queued;

    function automatic logic [COUNT_BITS-1:0] len_of(bbtk_pkg::kind_t k);
        logic [bbtk_pkg::LEN_W-1:0] raw;
        case (k)
            bbtk_pkg::KIND_SHORT:    raw = short_len;
            bbtk_pkg::KIND_LONG:     raw = long_len;
            bbtk_pkg::KIND_BIT_GAP:  raw = bit_gap_len;
            bbtk_pkg::KIND_BYTE_GAP: raw = byte_gap_len;
            bbtk_pkg::KIND_END:      raw = end_len;
            default:                 raw = '0;
        endcase
        if (33'(raw) > 33'(CountMax))
            return CountMax;
        return COUNT_BITS'(raw);
    endfunction

    assign busy       = (seg_reg != bbtk_pkg::KIND_IDLE);
    assign pop        = q_valid && advance;
    assign left_dec   = left_reg - COUNT_BITS'(1);

    always_comb
    begin
        len_first  = len_of(first_k);
        len_second = len_of(second_k);
        len_queued = len_of(queued_reg);
    end

    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        seg_next       = seg_reg;
        queued_next    = queued_reg;
        gap_next       = gap_reg;
        open_next      = open_reg;
        flags          = '0;
        first_k        = bbtk_pkg::KIND_IDLE;
        second_k       = bbtk_pkg::KIND_IDLE;
        do_launch      = 1'b0;

        case (q_cmd)
            bbtk_pkg::CMD_TICK:
            begin
                if (busy)
                begin
                    flags.tone = (seg_reg == bbtk_pkg::KIND_SHORT) ||
                                 (seg_reg == bbtk_pkg::KIND_LONG) ||
                                 (seg_reg == bbtk_pkg::KIND_END);
                    if (flags.tone)
                        phase_next = phase_reg +
                            ((seg_reg == bbtk_pkg::KIND_END) ? end_inc : tone_inc);
                    flags.playing = 1'b1;
                    left_next     = left_dec;
                    if (left_dec == '0)
                    begin
                        queued_next = bbtk_pkg::KIND_IDLE;
                        seg_next    = bbtk_pkg::KIND_IDLE;
                        if (queued_reg != bbtk_pkg::KIND_IDLE)
                        begin
                            phase_next = '0;
                            if (len_queued != '0)
                            begin
                                seg_next  = queued_reg;
                                left_next = len_queued;
                            end
                        end
                    end
                end
            end
            bbtk_pkg::CMD_BIT0, bbtk_pkg::CMD_BIT1:
            begin
                if (!busy)
                begin
                    flags.accepted = 1'b1;
                    do_launch      = 1'b1;
                    first_k        = gap_reg ? bbtk_pkg::KIND_BIT_GAP : bbtk_pkg::KIND_IDLE;
                    second_k       = (q_cmd == bbtk_pkg::CMD_BIT0) ?
                                     bbtk_pkg::KIND_SHORT : bbtk_pkg::KIND_LONG;
                    gap_next       = 1'b1;
                    open_next      = 1'b1;
                end
            end
            bbtk_pkg::CMD_SPACE:
            begin
                if (!busy)
                begin
                    flags.accepted = 1'b1;
                    if (open_reg)
                    begin
                        do_launch = 1'b1;
                        first_k   = bbtk_pkg::KIND_BYTE_GAP;
                        gap_next  = 1'b0;
                        open_next = 1'b0;
                    end
                end
            end
            bbtk_pkg::CMD_END:
            begin
                if (!busy)
                begin
                    flags.accepted = 1'b1;
                    do_launch      = 1'b1;
                    first_k        = gap_reg ? bbtk_pkg::KIND_BIT_GAP : bbtk_pkg::KIND_IDLE;
                    second_k       = bbtk_pkg::KIND_END;
                    gap_next       = 1'b0;
                    open_next      = 1'b0;
                end
            end
            bbtk_pkg::CMD_OTHER:
            begin
                flags.accepted = !busy;
            end
            default:
            begin
                flags = '0;
            end
        endcase

        if (do_launch)
        begin
            queued_next = bbtk_pkg::KIND_IDLE;
            if (first_k != bbtk_pkg::KIND_IDLE)
                phase_next = '0;
            if ((first_k != bbtk_pkg::KIND_IDLE) && (len_first != '0))
            begin
                seg_next    = first_k;
                left_next   = len_first;
                queued_next = second_k;
            end
            else if (second_k != bbtk_pkg::KIND_IDLE)
            begin
                phase_next = '0;
                if (len_second != '0)
                begin
                    seg_next  = second_k;
                    left_next = len_second;
                end
            end
        end

        flags.idle = (seg_next == bbtk_pkg::KIND_IDLE) &&
                     (queued_next == bbtk_pkg::KIND_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            left_reg     <= '0;
            seg_reg      <= bbtk_pkg::KIND_IDLE;
            queued_reg   <= bbtk_pkg::KIND_IDLE;
            gap_reg      <= 1'b0;
            open_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg  <= phase_next;
                left_reg   <= left_next;
                seg_reg    <= seg_next;
                queued_reg <= queued_next;
                gap_reg    <= gap_next;
                open_reg   <= open_next;
            end
            if (advance)
                s1_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_flags_reg <= flags;
            s1_index_reg <= phase_reg[bbtk_pkg::INC_W-1 -: SINE_TABLE_BITS];
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_flags = s1_flags_reg;
    assign s1_index = s1_index_reg;

    `BBTK_ASSERT_ALWAYS(a_count_live, (seg_reg == bbtk_pkg::KIND_IDLE) == (left_reg == '0))
    `BBTK_ASSERT_ALWAYS(a_queue_behind, (queued_reg == bbtk_pkg::KIND_IDLE) || (seg_reg != bbtk_pkg::KIND_IDLE))
    `BBTK_ASSERT_ALWAYS(a_gap_in_byte, !gap_reg || open_reg)

endmodule
`default_nettype wire

/* rtl/bbtk_tone.sv */
// Tone path: sine lookup, amplitude scaling and the output register.
`default_nettype none
module bbtk_tone
#(
    parameter int SINE_TABLE_BITS = bbtk_pkg::SINE_TABLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s1_valid,
    input  wire bbtk_pkg::res_flags_t          s1_flags,
    input  wire logic [SINE_TABLE_BITS-1:0]    s1_index,
    input  wire logic [bbtk_pkg::AMP_W-1:0]    amplitude,
    output logic                               advance,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bbtk_pkg::SAMPLE_W-1:0]      out_sample,
    output bbtk_pkg::res_flags_t               out_flags
);

    localparam int QuarterLen = 1 << (SINE_TABLE_BITS - 2);
    localparam int ProdW      = bbtk_pkg::MAG_W + bbtk_pkg::AMP_W;

    logic [bbtk_pkg::MAG_W-1:0]    quarter_tab [QuarterLen+1];
    logic [1:0]                    quad;
    logic [SINE_TABLE_BITS-3:0]    off;
    logic [SINE_TABLE_BITS-2:0]    tab_addr;
    logic [bbtk_pkg::MAG_W-1:0]    mag;

    logic                          s2_valid_reg;
    bbtk_pkg::res_flags_t          s2_flags_reg;
    logic [bbtk_pkg::MAG_W-1:0]    s2_mag_reg;
    logic                          s2_neg_reg;

    logic [ProdW-1:0]              prod;
    logic [bbtk_pkg::SAMPLE_W-1:0] scaled;
    logic [bbtk_pkg::SAMPLE_W-1:0] sample;

    logic                          out_valid_reg;
    logic [bbtk_pkg::SAMPLE_W-1:0] out_sample_reg;
    bbtk_pkg::res_flags_t          out_flags_reg;

    for (genvar k = 0; k <= QuarterLen; k++)
    begin : g_tab
        assign quarter_tab[k] = bbtk_pkg::quarter_sine(k, SINE_TABLE_BITS);
    end

    assign quad     = s1_index[SINE_TABLE_BITS-1 -: 2];
    assign off      = s1_index[SINE_TABLE_BITS-3:0];
    assign tab_addr = quad[0] ? ((SINE_TABLE_BITS-1)'(QuarterLen) - {1'b0, off})
                              : {1'b0, off};
    assign mag      = s1_flags.tone ? quarter_tab[tab_addr] : '0;

    assign prod   = s2_mag_reg * amplitude;
    assign scaled = {1'b0, prod[ProdW-1 -: bbtk_pkg::MAG_W]};
    assign sample = s2_neg_reg ? (~scaled + 1'b1) : scaled;

    assign advance = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s1_valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_flags_reg   <= s1_flags;
            s2_mag_reg     <= mag;
            s2_neg_reg     <= quad[1];
            out_flags_reg  <= s2_flags_reg;
            out_sample_reg <= sample;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_flags  = out_flags_reg;

endmodule
`default_nettype wire

/* rtl/binary_beep_tone_keyer_core.sv */
// Top level of the on-off keyed tone generator: config registers and pipeline.
//
//  port group  dir  content
//  s_*         in   tuser = req_type[1:0]; tdata = char_code[7:0]
//  m_*         out  tdata = sample[15:0], playing[16], accepted[17], idle[18]
//  cfg_*       in   register write: cfg_index selects, cfg_data carries value
//
// One item per cycle sustained while m_tready does not stall; each result passes through
// the queue, sequencer stage, sine lookup stage and scale/output register.
// The sequencer updates segment state once per item, so items issue
// back to back. A stalled m_tready freezes the whole back end; the two-entry
// queue keeps s_tready high until it is full. Reset is asynchronous and
// loads the register defaults; no clearing pass is needed.
`default_nettype none
module binary_beep_tone_keyer_core
#(
    parameter int SINE_TABLE_BITS = bbtk_pkg::SINE_TABLE_BITS_DEF,
    parameter int COUNT_BITS      = bbtk_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bbtk_pkg::CHAR_W-1:0]       s_tdata,     // char_code
    input  wire logic [bbtk_pkg::REQ_W-1:0]        s_tuser,     // req_type
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [bbtk_pkg::OUT_TDATA_W-1:0]       m_tdata,     // sample, playing, accepted, idle
    input  wire logic                              cfg_we,
    input  wire logic [bbtk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bbtk_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [bbtk_pkg::LEN_W-1:0]    short_reg;
    logic [bbtk_pkg::LEN_W-1:0]    long_reg;
    logic [bbtk_pkg::LEN_W-1:0]    bit_gap_reg;
    logic [bbtk_pkg::LEN_W-1:0]    byte_gap_reg;
    logic [bbtk_pkg::LEN_W-1:0]    end_reg;
    logic [bbtk_pkg::INC_W-1:0]    tone_inc_reg;
    logic [bbtk_pkg::INC_W-1:0]    end_inc_reg;
    logic [bbtk_pkg::AMP_W-1:0]    amp_reg;

    logic                          advance;
    logic                          q_valid;
    bbtk_pkg::cmd_t                q_cmd;
    logic                          s1_valid;
    bbtk_pkg::res_flags_t          s1_flags;
    logic [SINE_TABLE_BITS-1:0]    s1_index;
    logic [bbtk_pkg::SAMPLE_W-1:0] out_sample;
    bbtk_pkg::res_flags_t          out_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg    <= bbtk_pkg::SHORT_RST;
            long_reg     <= bbtk_pkg::LONG_RST;
            bit_gap_reg  <= bbtk_pkg::BIT_GAP_RST;
            byte_gap_reg <= bbtk_pkg::BYTE_GAP_RST;
            end_reg      <= bbtk_pkg::END_RST;
            tone_inc_reg <= bbtk_pkg::TONE_INC_RST;
            end_inc_reg  <= bbtk_pkg::END_INC_RST;
            amp_reg      <= bbtk_pkg::AMP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbtk_pkg::CFG_SHORT:    short_reg    <= cfg_data[bbtk_pkg::LEN_W-1:0];
                bbtk_pkg::CFG_LONG:     long_reg     <= cfg_data[bbtk_pkg::LEN_W-1:0];
                bbtk_pkg::CFG_BIT_GAP:  bit_gap_reg  <= cfg_data[bbtk_pkg::LEN_W-1:0];
                bbtk_pkg::CFG_BYTE_GAP: byte_gap_reg <= cfg_data[bbtk_pkg::LEN_W-1:0];
                bbtk_pkg::CFG_END:      end_reg      <= cfg_data[bbtk_pkg::LEN_W-1:0];
                bbtk_pkg::CFG_TONE_INC: tone_inc_reg <= cfg_data[bbtk_pkg::INC_W-1:0];
                bbtk_pkg::CFG_END_INC:  end_inc_reg  <= cfg_data[bbtk_pkg::INC_W-1:0];
                bbtk_pkg::CFG_AMP:      amp_reg      <= cfg_data[bbtk_pkg::AMP_W-1:0];
                default:                amp_reg      <= amp_reg;
            endcase
        end
    end

    bbtk_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    bbtk_back
    #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .COUNT_BITS      (COUNT_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .short_len    (short_reg),
        .long_len     (long_reg),
        .bit_gap_len  (bit_gap_reg),
        .byte_gap_len (byte_gap_reg),
        .end_len      (end_reg),
        .tone_inc     (tone_inc_reg),
        .end_inc      (end_inc_reg),
        .s1_valid     (s1_valid),
        .s1_flags     (s1_flags),
        .s1_index     (s1_index)
    );

    bbtk_tone
    #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    )
    u_tone
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_flags   (s1_flags),
        .s1_index   (s1_index),
        .amplitude  (amp_reg),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (out_sample),
        .out_flags  (out_flags)
    );

    assign m_tdata = {5'b0, out_flags.idle, out_flags.accepted, out_flags.playing, out_sample};

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for the on-off keyed tone generator core with stream stalls.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bbtk_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 40;
    localparam int LAST_ITEMS     = 20;
    localparam int LAST_PHASE     = 9;
    localparam int QUARTER        = 1 << (SINE_TABLE_BITS_DEF - 2);
    localparam logic [LEN_W-1:0]  LEN_MAX    = 20'hFFFFF;
    localparam logic [INC_W-1:0]  INC_MAX    = 32'h8000_0000;
    localparam logic [REQ_W-1:0]  REQ_UNUSED = 2'd3;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] code;
    } keyer_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       playing;
        logic                       accepted;
        logic                       idle;
    } keyer_out_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [CHAR_W-1:0]        s_tdata   = '0;   // char_code
    logic [REQ_W-1:0]         s_tuser   = '0;   // req_type
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_tdata;          // sample, playing, accepted, idle
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    binary_beep_tone_keyer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    keyer_req_t keyer_requests[$];
    keyer_out_t keyer_outputs[$];
    keyer_out_t out_want;

    // predictor registers and state
    logic [LEN_W-1:0] short_len    = SHORT_RST;
    logic [LEN_W-1:0] long_len     = LONG_RST;
    logic [LEN_W-1:0] bit_gap_len  = BIT_GAP_RST;
    logic [LEN_W-1:0] byte_gap_len = BYTE_GAP_RST;
    logic [LEN_W-1:0] end_len      = END_RST;
    logic [INC_W-1:0] tone_step    = TONE_INC_RST;
    logic [INC_W-1:0] end_step     = END_INC_RST;
    logic [AMP_W-1:0] amp_gain     = AMP_RST;

    logic [INC_W-1:0] tone_phase   = '0;
    logic [LEN_W-1:0] seg_left     = '0;
    kind_t            seg_kind     = KIND_IDLE;
    kind_t            next_kind    = KIND_IDLE;
    logic             gap_held     = 1'b0;
    logic             byte_open_q  = 1'b0;

    int sine_q [0:QUARTER];

    int errors         = 0;
    int items_seen     = 0;
    int tone_samples   = 0;
    int silent_samples = 0;
    int refused        = 0;
    int settings_used  = 0;
    int stall_cycles   = 0;
    int send_idle_pct  = 15;
    int recv_idle_pct  = 70;

    function automatic int tone_value(logic [INC_W-1:0] ph);
        int idx, quad, off, v;
        idx  = int'(ph >> (32 - SINE_TABLE_BITS_DEF));
        quad = (idx >> (SINE_TABLE_BITS_DEF - 2)) & 3;
        off  = idx & (QUARTER - 1);
        v    = (quad & 1) ? sine_q[QUARTER - off] : sine_q[off];
        return (quad & 2) ? -v : v;
    endfunction

    function automatic logic [LEN_W-1:0] segment_length(kind_t k);
        case (k)
            KIND_SHORT:    return short_len;
            KIND_LONG:     return long_len;
            KIND_BIT_GAP:  return bit_gap_len;
            KIND_BYTE_GAP: return byte_gap_len;
            KIND_END:      return end_len;
            default:       return '0;
        endcase
    endfunction

    // zero length leaves the keyer idle
    function automatic bit start_segment(kind_t k);
        logic [LEN_W-1:0] len;
        len        = segment_length(k);
        tone_phase = '0;
        if (len == '0)
        begin
            seg_kind = KIND_IDLE;
            seg_left = '0;
            return 1'b0;
        end
        seg_kind = k;
        seg_left = len;
        return 1'b1;
    endfunction

    function automatic void launch_segments(kind_t first, kind_t second);
        next_kind = KIND_IDLE;
        if (first != KIND_IDLE && start_segment(first))
            next_kind = second;
        else if (second != KIND_IDLE)
            void'(start_segment(second));
    endfunction

    function automatic keyer_out_t step_keyer(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] code);
        keyer_out_t r;
        bit         busy;
        int         s, m;
        kind_t      gap_k, bit_k, follow_k;
        r     = '0;
        busy  = seg_kind != KIND_IDLE;
        gap_k = KIND_IDLE;
        if (gap_held)
            gap_k = KIND_BIT_GAP;
        items_seen++;
        if (req == REQ_TICK)
        begin
            if (busy)
            begin
                if (seg_kind == KIND_SHORT || seg_kind == KIND_LONG || seg_kind == KIND_END)
                begin
                    s = tone_value(tone_phase);
                    m = ((s < 0 ? -s : s) * int'(amp_gain)) >>> 15;
                    r.sample = SAMPLE_W'(s < 0 ? -m : m);
                    tone_phase += (seg_kind == KIND_END) ? end_step : tone_step;
                    tone_samples++;
                end
                else
                    silent_samples++;
                r.playing = 1'b1;
                seg_left  = seg_left - 1'b1;
                if (seg_left == '0)
                begin
                    follow_k  = next_kind;
                    next_kind = KIND_IDLE;
                    seg_kind  = KIND_IDLE;
                    if (follow_k != KIND_IDLE)
                        void'(start_segment(follow_k));
                end
            end
        end
        else if ((req == REQ_CHAR || req == REQ_END) && busy)
            refused++;
        else if (req == REQ_CHAR)
        begin
            r.accepted = 1'b1;
            if (code == CH_ZERO || code == CH_ONE)
            begin
                bit_k = KIND_LONG;
                if (code == CH_ZERO)
                    bit_k = KIND_SHORT;
                launch_segments(gap_k, bit_k);
                gap_held    = 1'b1;
                byte_open_q = 1'b1;
            end
            else if (code == CH_SPACE && byte_open_q)
            begin
                gap_held    = 1'b0;
                byte_open_q = 1'b0;
                launch_segments(KIND_BYTE_GAP, KIND_IDLE);
            end
        end
        else if (req == REQ_END)
        begin
            r.accepted = 1'b1;
            launch_segments(gap_k, KIND_END);
            gap_held    = 1'b0;
            byte_open_q = 1'b0;
        end
        r.idle = seg_kind == KIND_IDLE && next_kind == KIND_IDLE;
        return r;
    endfunction

    task automatic queue_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] code);
        keyer_requests.push_back('{req: req, code: code});
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_request(REQ_TICK, CHAR_W'($urandom));
    endtask

    // bursts with random content, mostly well formed, some noise
    task automatic queue_random_message(int count);
        int made, r;
        made = 0;
        while (made < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                queue_request(REQ_CHAR, $urandom_range(0, 1) ? CH_ONE : CH_ZERO);
                queue_ticks($urandom_range(0, 12));
                made++;
            end
            else if (r < 50)
            begin
                queue_request(REQ_CHAR, CH_SPACE);
                queue_ticks($urandom_range(0, 8));
                made++;
            end
            else if (r < 56)
            begin
                queue_request(REQ_END, CHAR_W'($urandom));
                queue_ticks($urandom_range(0, 14));
                made++;
            end
            else if (r < 66)
            begin
                case ($urandom_range(0, 3))
                    0:       queue_request(REQ_CHAR, CH_LF);
                    1:       queue_request(REQ_CHAR, CH_CR);
                    2:       queue_request(REQ_CHAR, CHAR_W'($urandom));
                    default: queue_request(REQ_UNUSED, CHAR_W'($urandom));
                endcase
            end
            else
            begin
                queue_ticks($urandom_range(1, 6));
                made++;
            end
        end
    endtask

    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SHORT:    short_len    = val[LEN_W-1:0];
            CFG_LONG:     long_len     = val[LEN_W-1:0];
            CFG_BIT_GAP:  bit_gap_len  = val[LEN_W-1:0];
            CFG_BYTE_GAP: byte_gap_len = val[LEN_W-1:0];
            CFG_END:      end_len      = val[LEN_W-1:0];
            CFG_TONE_INC: tone_step    = val;
            CFG_END_INC:  end_step     = val;
            CFG_AMP:      amp_gain     = val[AMP_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic wait_drained();
        while (keyer_requests.size() != 0 || s_tvalid || keyer_outputs.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                keyer_outputs.push_back(step_keyer(s_tuser, s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (keyer_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= keyer_requests[0].req;
                    s_tdata  <= keyer_requests[0].code;
                    void'(keyer_requests.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (keyer_outputs.size() == 0)
                begin
                    $display("%0t: item with none outstanding: expected none actual %h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    out_want = keyer_outputs.pop_front();
                    if (m_tdata[15:0] !== out_want.sample)
                    begin
                        $display("%0t: sample expected %0d actual %0d", $time,
                                 out_want.sample, $signed(m_tdata[15:0]));
                        errors++;
                    end
                    if (m_tdata[16] !== out_want.playing)
                    begin
                        $display("%0t: playing expected %0b actual %0b", $time,
                                 out_want.playing, m_tdata[16]);
                        errors++;
                    end
                    if (m_tdata[17] !== out_want.accepted)
                    begin
                        $display("%0t: accepted expected %0b actual %0b", $time,
                                 out_want.accepted, m_tdata[17]);
                        errors++;
                    end
                    if (m_tdata[18] !== out_want.idle)
                    begin
                        $display("%0t: idle expected %0b actual %0b", $time,
                                 out_want.idle, m_tdata[18]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("binary_beep_tone_keyer_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] reg_val [0:7];
        int num_regs;
        for (int k = 0; k <= QUARTER; k++)
            sine_q[k] = $rtoi(32767.0 * $sin(TWO_PI * k / real'(4 * QUARTER)) + 0.5);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: only items that leave the keyer idle
        queue_request(REQ_TICK, '0);
        queue_request(REQ_CHAR, CH_LF);
        queue_request(REQ_CHAR, CH_CR);
        queue_request(REQ_CHAR, CH_SPACE);
        queue_request(REQ_CHAR, 8'hFF);
        queue_request(REQ_UNUSED, CH_ONE);
        wait_drained();

        for (int p = 1; p <= LAST_PHASE; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 70;
            end
            else if (p < 6)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            reg_val[CFG_SHORT]    = $urandom_range(0, 9);
            reg_val[CFG_LONG]     = $urandom_range(0, 9);
            reg_val[CFG_BIT_GAP]  = $urandom_range(0, 9);
            reg_val[CFG_BYTE_GAP] = $urandom_range(0, 9);
            reg_val[CFG_END]      = $urandom_range(0, 9);
            reg_val[CFG_TONE_INC] = $urandom_range(0, INC_MAX);
            reg_val[CFG_END_INC]  = $urandom_range(0, INC_MAX);
            reg_val[CFG_AMP]      = $urandom_range(0, 32767);
            num_regs = 8;
            case (p)
                1:
                begin
                    // short lengths, tone and amplitude keep their reset values
                    reg_val[CFG_SHORT]    = 2;
                    reg_val[CFG_LONG]     = 3;
                    reg_val[CFG_BIT_GAP]  = 1;
                    reg_val[CFG_BYTE_GAP] = 2;
                    reg_val[CFG_END]      = 3;
                    num_regs = 5;
                end
                2:
                begin
                    reg_val[CFG_SHORT]    = $urandom_range(1, 6);
                    reg_val[CFG_LONG]     = $urandom_range(1, 6);
                    reg_val[CFG_BIT_GAP]  = $urandom_range(1, 6);
                    reg_val[CFG_BYTE_GAP] = $urandom_range(1, 6);
                    reg_val[CFG_END]      = $urandom_range(1, 6);
                    reg_val[CFG_TONE_INC] = '0;
                    reg_val[CFG_END_INC]  = INC_MAX;
                    reg_val[CFG_AMP]      = 32767;
                end
                3:
                begin
                    reg_val[CFG_BIT_GAP]  = '0;
                    reg_val[CFG_TONE_INC] = INC_MAX;
                    reg_val[CFG_END_INC]  = '0;
                    reg_val[CFG_AMP]      = '0;
                end
                4:
                begin
                    reg_val[CFG_BYTE_GAP] = '0;
                    reg_val[CFG_END]      = '0;
                end
                5:
                    reg_val[CFG_SHORT] = '0;
                LAST_PHASE:
                begin
                    reg_val[CFG_SHORT]    = LEN_MAX;
                    reg_val[CFG_LONG]     = LEN_MAX;
                    reg_val[CFG_BIT_GAP]  = LEN_MAX;
                    reg_val[CFG_BYTE_GAP] = LEN_MAX;
                    reg_val[CFG_END]      = LEN_MAX;
                    reg_val[CFG_AMP]      = 32767;
                end
                default: ;
            endcase
            for (int i = 0; i < num_regs; i++)
                write_setting(CFG_IDX_W'(i), reg_val[i]);
            settings_used++;

            if (p == 1)
            begin
                queue_request(REQ_CHAR, CH_ZERO);
                queue_ticks(2);
                queue_request(REQ_CHAR, CH_ONE);     // held gap then long burst
                queue_request(REQ_CHAR, CH_ONE);     // busy, refused
                queue_ticks(4);
                queue_request(REQ_CHAR, CH_SPACE);   // drops held gap, byte gap
                queue_ticks(2);
                queue_request(REQ_CHAR, CH_ONE);
                queue_ticks(1);
                queue_request(REQ_END, '0);          // busy, refused
                queue_ticks(2);
                queue_request(REQ_END, '0);          // held gap then end tone
                queue_ticks(5);
            end
            else
                queue_random_message(p == LAST_PHASE ? LAST_ITEMS : RANDOM_ITEMS);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d items over %0d register settings", items_seen, settings_used);
        $display("%0d tone samples, %0d gap samples, %0d requests refused while busy",
                 tone_samples, silent_samples, refused);
        if (errors == 0 && keyer_outputs.size() == 0)
            $display("binary_beep_tone_keyer_core: match");
        else
            $display("binary_beep_tone_keyer_core: mismatch");
        $finish;
    end

endmodule
